[sv/mxt_pkg.sv]
// Shared constants, controller states and command/status types for the max XOR pair trie.
package mxt_pkg;

   localparam int FIELD_BITS         = 31;
   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int MAX_ITEMS_DEFAULT  = 1024;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_INSERT,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic query_step;
      logic insert_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic query_done;
      logic insert_done;
      logic last;
      logic out_free;
   } sts_type;

endpackage

[sv/mxt_ram.sv]
// Generic single-port RAM with registered read data.
module mxt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mxt_ctrl.sv]
// Sequencing state machine: accept, query walk, insert walk, result hand-off.
module mxt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_item,
   output logic             req_stall,
   input  mxt_pkg::sts_type sts,
   output mxt_pkg::cmd_type cmd
);

   mxt_pkg::ctrl_state_type state_ff;
   mxt_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mxt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mxt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (sts.full) begin
                  state_in = req_last_item ? mxt_pkg::ST_EMIT : mxt_pkg::ST_IDLE;
               end else if (sts.empty) begin
                  state_in = mxt_pkg::ST_INSERT;
               end else begin
                  state_in = mxt_pkg::ST_QUERY;
               end
            end
         end
         mxt_pkg::ST_QUERY: begin
            if (sts.query_done) begin
               state_in = mxt_pkg::ST_INSERT;
            end
         end
         mxt_pkg::ST_INSERT: begin
            if (sts.insert_done) begin
               state_in = sts.last ? mxt_pkg::ST_EMIT : mxt_pkg::ST_IDLE;
            end
         end
         mxt_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               state_in = mxt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mxt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mxt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mxt_pkg::ST_QUERY: begin
            cmd.query_step = 1'b1;
         end
         mxt_pkg::ST_INSERT: begin
            cmd.insert_step = 1'b1;
         end
         mxt_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[sv/mxt_dp.sv]
// Trie datapath: node pool, walk registers, running maximum and result register.
module mxt_dp #(
   parameter int VALUE_BITS = mxt_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_ITEMS  = mxt_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mxt_pkg::cmd_type               cmd,
   output mxt_pkg::sts_type               sts,
   input  logic [mxt_pkg::FIELD_BITS-1:0] req_value,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mxt_pkg::FIELD_BITS-1:0] rsp_max_xor,
   output logic                           rsp_overflow
);

   localparam int FB         = mxt_pkg::FIELD_BITS;
   localparam int POOL_NODES = 1 + MAX_ITEMS * VALUE_BITS;
   localparam int LINK_BITS  = $clog2(POOL_NODES);
   localparam int LVL_BITS   = $clog2(VALUE_BITS);
   localparam int ITEM_BITS  = $clog2(MAX_ITEMS + 1);
   localparam logic [LVL_BITS-1:0]  LVL_TOP   = LVL_BITS'(VALUE_BITS - 1);
   localparam logic [LINK_BITS-1:0] NODE_LAST = LINK_BITS'(POOL_NODES - 1);
   localparam logic [ITEM_BITS-1:0] ITEM_FULL = ITEM_BITS'(MAX_ITEMS);

   // item and walk registers
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  last_ff, last_in;
   logic [LVL_BITS-1:0]   level_ff, level_in;
   logic [LINK_BITS-1:0]  node_ff, node_in;
   logic                  at_root_ff, at_root_in;
   logic                  fresh_ff, fresh_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;

   // set state
   logic [LINK_BITS-1:0]  root0_ff, root0_in;
   logic [LINK_BITS-1:0]  root1_ff, root1_in;
   logic [LINK_BITS-1:0]  node_count_ff, node_count_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [ITEM_BITS-1:0]  item_count_ff, item_count_in;
   logic                  overflow_ff, overflow_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0]         rsp_max_xor_ff, rsp_max_xor_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   logic [FB+VALUE_BITS-1:0] value_wide;
   logic [FB+VALUE_BITS-1:0] best_wide;

   logic [LINK_BITS-1:0]   cur0, cur1;
   logic                   bit_cur;
   logic [LINK_BITS-1:0]   want, alt;
   logic [VALUE_BITS-1:0]  level_bit;
   logic                   q_hit, q_dead, q_done;
   logic [LINK_BITS-1:0]   q_next;
   logic [VALUE_BITS-1:0]  q_acc;
   logic                   i_need, i_stop, i_alloc, i_done;
   logic [LINK_BITS-1:0]   new_node;
   logic                   out_free;

   logic                   ram_we;
   logic [LINK_BITS-1:0]   ram_addr;
   logic [2*LINK_BITS-1:0] ram_wdata;
   logic [2*LINK_BITS-1:0] ram_rdata;

   mxt_ram #(
      .WIDTH (2 * LINK_BITS),
      .DEPTH (POOL_NODES)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign value_wide = {{VALUE_BITS{1'b0}}, req_value};
   assign best_wide  = {{FB{1'b0}}, best_ff};

   // links of the node under the walk: root flops, a freshly allocated node, or pool data
   always_comb begin
      cur0 = root0_ff;
      cur1 = root1_ff;
      if (fresh_ff) begin
         cur0 = '0;
         cur1 = '0;
      end else if (!at_root_ff) begin
         cur0 = ram_rdata[LINK_BITS-1:0];
         cur1 = ram_rdata[2*LINK_BITS-1:LINK_BITS];
      end
   end

   assign bit_cur   = value_ff[level_ff];
   assign want      = bit_cur ? cur0 : cur1;
   assign alt       = bit_cur ? cur1 : cur0;
   assign level_bit = VALUE_BITS'(1) << level_ff;

   assign q_hit  = (want != '0);
   assign q_dead = !q_hit && (alt == '0);
   assign q_next = q_hit ? want : alt;
   assign q_acc  = q_hit ? (acc_ff | level_bit) : acc_ff;
   assign q_done = q_dead || (level_ff == '0);

   assign new_node = node_count_ff + LINK_BITS'(1);
   assign i_need   = (alt == '0);
   assign i_stop   = i_need && (node_count_ff >= NODE_LAST);
   assign i_alloc  = i_need && !i_stop;
   assign i_done   = i_stop || (level_ff == '0);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign ram_we    = cmd.insert_step && i_alloc && !at_root_ff;
   assign ram_addr  = ram_we ? node_ff : (cmd.query_step ? q_next : alt);
   assign ram_wdata = bit_cur ? {new_node, cur0} : {cur1, new_node};

   always_comb begin
      sts.full        = (item_count_ff >= ITEM_FULL);
      sts.empty       = (item_count_ff == '0);
      sts.query_done  = q_done;
      sts.insert_done = i_done;
      sts.last        = last_ff;
      sts.out_free    = out_free;
   end

   always_comb begin
      value_in        = value_ff;
      last_in         = last_ff;
      level_in        = level_ff;
      node_in         = node_ff;
      at_root_in      = at_root_ff;
      fresh_in        = fresh_ff;
      acc_in          = acc_ff;
      root0_in        = root0_ff;
      root1_in        = root1_ff;
      node_count_in   = node_count_ff;
      best_in         = best_ff;
      item_count_in   = item_count_ff;
      overflow_in     = overflow_ff;
      rsp_max_xor_in  = rsp_max_xor_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         value_in   = value_wide[VALUE_BITS-1:0];
         last_in    = req_last_item;
         level_in   = LVL_TOP;
         node_in    = '0;
         at_root_in = 1'b1;
         fresh_in   = 1'b0;
         acc_in     = '0;
         if (item_count_ff >= ITEM_FULL) begin
            overflow_in = 1'b1;
         end else begin
            item_count_in = item_count_ff + ITEM_BITS'(1);
         end
      end

      if (cmd.query_step) begin
         acc_in     = q_acc;
         node_in    = q_next;
         at_root_in = 1'b0;
         level_in   = level_ff - LVL_BITS'(1);
         if (q_done) begin
            if (q_acc > best_ff) begin
               best_in = q_acc;
            end
            node_in    = '0;
            at_root_in = 1'b1;
            fresh_in   = 1'b0;
            level_in   = LVL_TOP;
         end
      end

      if (cmd.insert_step) begin
         at_root_in = 1'b0;
         level_in   = level_ff - LVL_BITS'(1);
         if (i_alloc) begin
            node_count_in = new_node;
            node_in       = new_node;
            fresh_in      = 1'b1;
            if (at_root_ff) begin
               if (bit_cur) begin
                  root1_in = new_node;
               end else begin
                  root0_in = new_node;
               end
            end
         end else if (!i_stop) begin
            node_in = alt;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_max_xor_in  = best_wide[FB-1:0];
         rsp_overflow_in = overflow_ff;
         best_in         = '0;
         item_count_in   = '0;
         overflow_in     = 1'b0;
         root0_in        = '0;
         root1_in        = '0;
         node_count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_root_ff    <= 1'b1;
         fresh_ff      <= 1'b0;
         root0_ff      <= '0;
         root1_ff      <= '0;
         node_count_ff <= '0;
         best_ff       <= '0;
         item_count_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         at_root_ff    <= at_root_in;
         fresh_ff      <= fresh_in;
         root0_ff      <= root0_in;
         root1_ff      <= root1_in;
         node_count_ff <= node_count_in;
         best_ff       <= best_in;
         item_count_ff <= item_count_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      last_ff         <= last_in;
      level_ff        <= level_in;
      node_ff         <= node_in;
      acc_ff          <= acc_in;
      rsp_max_xor_ff  <= rsp_max_xor_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_xor  = rsp_max_xor_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[sv/max_xor_pair_trie.sv]
// Usage: values of a set arrive on req_value one per transfer, req_last_item on the final one.
// For each set the block returns one transfer on rsp_: the largest XOR of any two members
// (a member with itself counts, so a single member gives 0) and a flag for ignored items.
// Input channel: a transfer completes when req_valid is high and req_stall is low. req_stall
// is low only while the sequencer is idle, so one item is worked on at a time.
// Per item: an accept state, a query walk (skipped for the first item of a set) and an insert
// walk, one pool access per trie level. Items beyond MAX_ITEMS only raise the overflow flag.
// After the last item's transfer and any walks it needs, the hand-off state loads the result
// register once it is free. The result register parts the two sides: while a result waits
// under rsp_stall the block keeps accepting and processing items of the next set; only the
// next set's final item holds in the hand-off state until the register is taken.
// Reset (synchronous, active high) empties the trie, clears the maximum, counters and the
// overflow flag and drops any pending result. No clearing pass is needed: the root links
// live in flops and a freshly allocated node reads as empty until its links are written.
module max_xor_pair_trie #(
   parameter int VALUE_BITS = mxt_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_ITEMS  = mxt_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mxt_pkg::FIELD_BITS-1:0] req_value,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mxt_pkg::FIELD_BITS-1:0] rsp_max_xor,
   output logic                           rsp_overflow
);

   // commands from the sequencer, status back from the datapath
   mxt_pkg::cmd_type cmd;
   mxt_pkg::sts_type sts;

   // sequencer: decide per transfer whether to query, insert, ignore the item, or hand the result off
   mxt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   // datapath: node pool, walk registers, running maximum and result register
   mxt_dp #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_ITEMS  (MAX_ITEMS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_value),
      .req_last_item (req_last_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_max_xor   (rsp_max_xor),
      .rsp_overflow  (rsp_overflow)
   );

`ifndef NO_ASSERTIONS
   // hold off new transfers while a walk is using the pool
   assert property (@(posedge clock) disable iff (reset)
      (cmd.query_step || cmd.insert_step) |-> req_stall)
      else $error("input accepted during a trie walk");

   // a hand-off must land in the result register on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result hand-off did not raise rsp_valid");

   // a result only appears through a hand-off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("rsp_valid raised without a hand-off");
`endif

endmodule
